FILE: design/rsu_pkg.sv
`default_nettype none
package rsu_pkg;

    localparam int MAX_RUNS = 2048;
    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = AW + 1;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_UP = 2'd1;
    localparam logic [1:0] SH_DOWN = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TEST = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] op;
        logic [15:0] pos;
    } req_t;

    typedef struct packed {
        logic hit;
        logic overflow;
        logic [15:0] run_total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SWAIT,
        ST_RDP,
        ST_RDN,
        ST_DECIDE,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_WR1,
        ST_WR2,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: design/run_set_update.sv
`default_nettype none
// Run-length set of 16-bit values held in a single-port-read RAM of
// rsu_pkg::MAX_RUNS entries. One request is handled at a time: a binary
// search with a read and a compare per probe, then reads of the neighbor
// runs and a write-back, and opening or closing a run shifts every later
// entry one at a time, each read and then written back through the RAM.
// The run count is cleared by reset; no clearing pass is needed.
module run_set_update (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire rsu_pkg::req_t in_data,
    output logic out_valid,
    input wire logic out_ready,
    output rsu_pkg::rsp_t out_data
);

    localparam int AW = rsu_pkg::AW;
    localparam int CW = rsu_pkg::CW;

    rsu_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic [1:0] op_reg, op_next;
    logic [15:0] pos_reg, pos_next;
    logic [31:0] prv_reg, prv_next, nxt_reg, nxt_next;
    logic hasp_reg, hasp_next, hasn_reg, hasn_next;
    logic [31:0] w1_reg, w1_next, w2_reg, w2_next;
    logic [AW-1:0] a1_reg, a1_next, a2_reg, a2_next;
    logic [1:0] nw_reg, nw_next;
    logic [1:0] sh_reg, sh_next;
    logic [CW-1:0] at_reg, at_next;
    rsu_pkg::rsp_t rsp_reg, rsp_next;
    logic ov_reg, ov_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;
    logic [CW-1:0] mid;

    rsu_ram #(.WIDTH(32), .DEPTH(rsu_pkg::MAX_RUNS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign mid = CW'((lo_reg + hi_reg) >> 1);
    assign in_ready = (state_reg == rsu_pkg::ST_IDLE) && !out_valid;
    assign out_data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsu_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == rsu_pkg::ST_DONE)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next; idx_reg <= idx_next;
        op_reg <= op_next; pos_reg <= pos_next;
        prv_reg <= prv_next; nxt_reg <= nxt_next;
        hasp_reg <= hasp_next; hasn_reg <= hasn_next;
        w1_reg <= w1_next; w2_reg <= w2_next;
        a1_reg <= a1_next; a2_reg <= a2_next; nw_reg <= nw_next;
        sh_reg <= sh_next; at_reg <= at_next;
        rsp_reg <= rsp_next; ov_reg <= ov_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsu_pkg::ST_IDLE:
                if (in_valid && in_ready)
                    state_next = rsu_pkg::ST_SRCH;
            rsu_pkg::ST_SRCH:
                state_next = (lo_reg < hi_reg) ? rsu_pkg::ST_SWAIT : rsu_pkg::ST_RDP;
            rsu_pkg::ST_SWAIT: state_next = rsu_pkg::ST_SRCH;
            rsu_pkg::ST_RDP: state_next = rsu_pkg::ST_RDN;
            rsu_pkg::ST_RDN: state_next = rsu_pkg::ST_DECIDE;
            rsu_pkg::ST_DECIDE:
                unique case (sh_next)
                    rsu_pkg::SH_UP: state_next = rsu_pkg::ST_SHUP_RD;
                    rsu_pkg::SH_DOWN: state_next = rsu_pkg::ST_SHDN_RD;
                    default:
                        state_next = (nw_next != 2'd0) ? rsu_pkg::ST_WR1 : rsu_pkg::ST_DONE;
                endcase
            rsu_pkg::ST_SHUP_RD:
                state_next = (idx_reg > at_reg) ? rsu_pkg::ST_SHUP_WR : rsu_pkg::ST_WR1;
            rsu_pkg::ST_SHUP_WR: state_next = rsu_pkg::ST_SHUP_RD;
            rsu_pkg::ST_SHDN_RD:
                state_next = (idx_reg + 1'b1 < cnt_reg) ? rsu_pkg::ST_SHDN_WR
                                                         : rsu_pkg::ST_WR1;
            rsu_pkg::ST_SHDN_WR: state_next = rsu_pkg::ST_SHDN_RD;
            rsu_pkg::ST_WR1:
                state_next = (nw_reg == 2'd2) ? rsu_pkg::ST_WR2 : rsu_pkg::ST_DONE;
            rsu_pkg::ST_WR2: state_next = rsu_pkg::ST_DONE;
            rsu_pkg::ST_DONE: state_next = rsu_pkg::ST_IDLE;
            default: state_next = rsu_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        logic [15:0] ps, pl, ns, nl, off;
        logic full, nfuse;
        cnt_next = cnt_reg; lo_next = lo_reg; hi_next = hi_reg; idx_next = idx_reg;
        op_next = op_reg; pos_next = pos_reg; prv_next = prv_reg; nxt_next = nxt_reg;
        hasp_next = hasp_reg; hasn_next = hasn_reg; w1_next = w1_reg; w2_next = w2_reg;
        a1_next = a1_reg; a2_next = a2_reg; nw_next = nw_reg; sh_next = sh_reg;
        at_next = at_reg; rsp_next = rsp_reg; ov_next = ov_reg;
        we = 1'b0; waddr = a1_reg; wdata = w1_reg; raddr = mid[AW-1:0];
        ps = prv_reg[31:16]; pl = prv_reg[15:0];
        ns = nxt_reg[31:16]; nl = nxt_reg[15:0];
        off = pos_reg - ps;
        full = (cnt_reg == CW'(rsu_pkg::MAX_RUNS));
        nfuse = hasn_reg && (pos_reg != 16'hFFFF) && (ns == pos_reg + 16'd1);
        unique case (state_reg)
            rsu_pkg::ST_IDLE:
                if (in_valid && in_ready)
                begin
                    op_next = in_data.op; pos_next = in_data.pos;
                    lo_next = '0; hi_next = cnt_reg;
                end
            rsu_pkg::ST_SRCH:
            begin
                raddr = mid[AW-1:0];
                hasp_next = (lo_reg != '0);
                idx_next = lo_reg - 1'b1;
                hasn_next = (lo_reg < cnt_reg);
            end
            rsu_pkg::ST_SWAIT:
                if (rdata[31:16] <= pos_reg)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            rsu_pkg::ST_RDP: raddr = idx_reg[AW-1:0];
            rsu_pkg::ST_RDN:
            begin
                raddr = AW'(idx_reg + 1'b1);
                prv_next = rdata;
            end
            rsu_pkg::ST_DECIDE:
            begin
                nxt_next = rdata;
                ns = rdata[31:16]; nl = rdata[15:0];
                nfuse = hasn_reg && (pos_reg != 16'hFFFF) && (ns == pos_reg + 16'd1);
                nw_next = 2'd0; sh_next = rsu_pkg::SH_NONE; ov_next = 1'b0;
                rsp_next.hit = 1'b0;
                a1_next = idx_reg[AW-1:0];
                a2_next = AW'(idx_reg + 1'b1);
                unique case (op_reg)
                    rsu_pkg::OP_ADD:
                        if (hasp_reg && off <= pl)
                            rsp_next.hit = 1'b0;
                        else if (hasp_reg && {1'b0, off} == {1'b0, pl} + 17'd1)
                        begin
                            rsp_next.hit = 1'b1; nw_next = 2'd1;
                            if (nfuse)
                            begin
                                w1_next = {ps, 16'(ns + nl - ps)};
                                sh_next = rsu_pkg::SH_DOWN;
                                idx_next = idx_reg + 1'b1;
                            end
                            else
                                w1_next = {ps, 16'(pl + 16'd1)};
                        end
                        else if (nfuse)
                        begin
                            rsp_next.hit = 1'b1; nw_next = 2'd1;
                            a1_next = AW'(idx_reg + 1'b1);
                            w1_next = {pos_reg, 16'(nl + 16'd1)};
                        end
                        else if (full)
                            ov_next = 1'b1;
                        else
                        begin
                            rsp_next.hit = 1'b1; nw_next = 2'd1; sh_next = rsu_pkg::SH_UP;
                            at_next = idx_reg + 1'b1;
                            a1_next = AW'(idx_reg + 1'b1);
                            w1_next = {pos_reg, 16'd0};
                            idx_next = cnt_reg;
                        end
                    rsu_pkg::OP_REMOVE:
                        if (!hasp_reg)
                            rsp_next.hit = 1'b0;
                        else if (off == 16'd0)
                        begin
                            rsp_next.hit = 1'b1;
                            if (pl == 16'd0)
                                sh_next = rsu_pkg::SH_DOWN;
                            else
                            begin
                                nw_next = 2'd1;
                                w1_next = {16'(pos_reg + 16'd1), 16'(pl - 16'd1)};
                            end
                        end
                        else if (off < pl)
                        begin
                            if (full)
                                ov_next = 1'b1;
                            else
                            begin
                                rsp_next.hit = 1'b1; nw_next = 2'd2; sh_next = rsu_pkg::SH_UP;
                                at_next = idx_reg + 1'b1;
                                w1_next = {ps, 16'(off - 16'd1)};
                                w2_next = {16'(pos_reg + 16'd1), 16'(pl - off - 16'd1)};
                                idx_next = cnt_reg;
                            end
                        end
                        else if (off == pl)
                        begin
                            rsp_next.hit = 1'b1; nw_next = 2'd1;
                            w1_next = {ps, 16'(pl - 16'd1)};
                        end
                    rsu_pkg::OP_TEST:
                        rsp_next.hit = hasp_reg && (off <= pl);
                    default: rsp_next.hit = 1'b0;
                endcase
            end
            rsu_pkg::ST_SHUP_RD:
                raddr = AW'(idx_reg - 1'b1);
            rsu_pkg::ST_SHUP_WR:
            begin
                we = 1'b1; waddr = idx_reg[AW-1:0]; wdata = rdata;
                idx_next = idx_reg - 1'b1;
            end
            rsu_pkg::ST_SHDN_RD:
                raddr = AW'(idx_reg + 1'b1);
            rsu_pkg::ST_SHDN_WR:
            begin
                we = 1'b1; waddr = idx_reg[AW-1:0]; wdata = rdata;
                idx_next = idx_reg + 1'b1;
            end
            rsu_pkg::ST_WR1:
            begin
                we = (nw_reg != 2'd0); waddr = a1_reg; wdata = w1_reg;
            end
            rsu_pkg::ST_WR2:
            begin
                we = 1'b1; waddr = a2_reg; wdata = w2_reg;
            end
            rsu_pkg::ST_DONE:
            begin
                if (sh_reg == rsu_pkg::SH_UP)
                    cnt_next = cnt_reg + 1'b1;
                else if (sh_reg == rsu_pkg::SH_DOWN)
                    cnt_next = cnt_reg - 1'b1;
                rsp_next.overflow = ov_reg;
                rsp_next.run_total = 16'(cnt_next);
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(rsu_pkg::MAX_RUNS)) else $error("run count above capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rsu_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_ovf_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.overflow)) else $error("hit with overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rsu_pkg::ST_DONE) |=> $stable(cnt_reg)) else $error("count moved");
`endif

endmodule
`default_nettype wire

FILE: design/rsu_ram.sv
`default_nettype none
module rsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    class run_set_scoreboard;
        logic [15:0] run_head [rsu_pkg::MAX_RUNS];
        logic [15:0] run_len [rsu_pkg::MAX_RUNS];
        int run_count;
        rsu_pkg::rsp_t pending [$];
        int errors;
        int checked;

        function new();
            run_count = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int find_prev(logic [15:0] pos);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = run_count;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (run_head[mid] <= pos)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo - 1;
        endfunction

        function void open_slot(int at);
            for (int i = run_count; i > at; i--)
            begin
                run_head[i] = run_head[i - 1];
                run_len[i] = run_len[i - 1];
            end
            run_count++;
        endfunction

        function void close_slot(int at);
            for (int i = at; i + 1 < run_count; i++)
            begin
                run_head[i] = run_head[i + 1];
                run_len[i] = run_len[i + 1];
            end
            run_count--;
        endfunction

        function void apply_add(logic [15:0] pos, output logic hit, output logic ovf);
            int p;
            int at;
            int off;
            int le;
            int nxt;
            hit = 1'b0;
            ovf = 1'b0;
            p = find_prev(pos);
            if (p >= 0)
            begin
                off = int'(pos) - int'(run_head[p]);
                le = int'(run_len[p]);
                nxt = (p + 1 < run_count) ? int'(run_head[p + 1]) : -1;
                if (off <= le)
                    return;
                hit = 1'b1;
                if (off == le + 1)
                begin
                    if (nxt == int'(pos) + 1)
                    begin
                        run_len[p] = 16'(nxt + int'(run_len[p + 1]) - int'(run_head[p]));
                        close_slot(p + 1);
                    end
                    else
                        run_len[p] = 16'(le + 1);
                    return;
                end
                if (nxt == int'(pos) + 1)
                begin
                    run_head[p + 1] = pos;
                    run_len[p + 1] = run_len[p + 1] + 16'd1;
                    return;
                end
                at = p + 1;
            end
            else
            begin
                if (run_count > 0 && int'(run_head[0]) == int'(pos) + 1)
                begin
                    run_head[0] = pos;
                    run_len[0] = run_len[0] + 16'd1;
                    hit = 1'b1;
                    return;
                end
                at = 0;
            end
            if (run_count >= rsu_pkg::MAX_RUNS)
            begin
                hit = 1'b0;
                ovf = 1'b1;
                return;
            end
            open_slot(at);
            run_head[at] = pos;
            run_len[at] = 16'd0;
            hit = 1'b1;
        endfunction

        function void apply_remove(logic [15:0] pos, output logic hit, output logic ovf);
            int p;
            int off;
            int le;
            hit = 1'b0;
            ovf = 1'b0;
            p = find_prev(pos);
            if (p < 0)
                return;
            off = int'(pos) - int'(run_head[p]);
            le = int'(run_len[p]);
            if (off == 0)
            begin
                if (le == 0)
                    close_slot(p);
                else
                begin
                    run_head[p] = pos + 16'd1;
                    run_len[p] = 16'(le - 1);
                end
                hit = 1'b1;
            end
            else if (off < le)
            begin
                if (run_count >= rsu_pkg::MAX_RUNS)
                begin
                    ovf = 1'b1;
                    return;
                end
                run_len[p] = 16'(off - 1);
                open_slot(p + 1);
                run_head[p + 1] = pos + 16'd1;
                run_len[p + 1] = 16'(le - off - 1);
                hit = 1'b1;
            end
            else if (off == le)
            begin
                run_len[p] = 16'(le - 1);
                hit = 1'b1;
            end
        endfunction

        function logic is_member(logic [15:0] pos);
            int p;
            p = find_prev(pos);
            if (p < 0)
                return 1'b0;
            return (int'(pos) - int'(run_head[p])) <= int'(run_len[p]);
        endfunction

        function void note_request(rsu_pkg::req_t r);
            rsu_pkg::rsp_t e;
            logic h;
            logic o;
            h = 1'b0;
            o = 1'b0;
            case (rsu_pkg::op_t'(r.op))
                rsu_pkg::OP_ADD: apply_add(r.pos, h, o);
                rsu_pkg::OP_REMOVE: apply_remove(r.pos, h, o);
                rsu_pkg::OP_TEST: h = is_member(r.pos);
                default: ;
            endcase
            e.hit = h;
            e.overflow = o;
            e.run_total = 16'(run_count);
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(rsu_pkg::rsp_t got);
            rsu_pkg::rsp_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit)
                report("hit", int'(got.hit), int'(e.hit));
            if (got.overflow !== e.overflow)
                report("overflow", int'(got.overflow), int'(e.overflow));
            if (got.run_total !== e.run_total)
                report("run_total", int'(got.run_total), int'(e.run_total));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    rsu_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    rsu_pkg::rsp_t out_data;

    run_set_scoreboard sb;
    int gap;
    bit send_burst;
    bit recv_burst;
    bit hold_req;
    int stall;
    int cycles;

    run_set_update DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(out_data);
                stall = recv_burst ? 0 : $urandom_range(0, 3);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 400;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task send(input rsu_pkg::op_t op, input logic [15:0] pos);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= '{op: op, pos: pos};
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(in_data);
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0)
            in_valid <= 1'b0;
    endtask

    task wait_idle();
        if (gap == 0)
        begin
            in_valid <= 1'b0;
            gap = 1;
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function logic [15:0] pick_pos();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 16'($urandom_range(0, 200));
        else if (k < 80)
            return 16'($urandom_range(65500, 65535));
        else if (k < 90)
            return 16'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    function rsu_pkg::op_t pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return rsu_pkg::OP_ADD;
        else if (k < 70)
            return rsu_pkg::OP_REMOVE;
        else if (k < 95)
            return rsu_pkg::OP_TEST;
        else
            return rsu_pkg::OP_NONE;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        gap = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        hold_req = 1'b0;
        stall = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(rsu_pkg::OP_TEST, 16'd0);
        send(rsu_pkg::OP_REMOVE, 16'd0);
        send(rsu_pkg::OP_ADD, 16'hFFFF);
        send(rsu_pkg::OP_ADD, 16'hFFFE);
        send(rsu_pkg::OP_ADD, 16'd0);
        send(rsu_pkg::OP_ADD, 16'd2);
        send(rsu_pkg::OP_ADD, 16'd1);
        send(rsu_pkg::OP_TEST, 16'd1);
        send(rsu_pkg::OP_REMOVE, 16'd1);
        send(rsu_pkg::OP_REMOVE, 16'd0);
        send(rsu_pkg::OP_REMOVE, 16'd2);
        send(rsu_pkg::OP_NONE, 16'd5);
        send(rsu_pkg::OP_REMOVE, 16'hFFFF);
        send(rsu_pkg::OP_REMOVE, 16'hFFFE);
        send(rsu_pkg::OP_ADD, 16'd10);
        send(rsu_pkg::OP_ADD, 16'd12);
        send(rsu_pkg::OP_ADD, 16'd11);
        send(rsu_pkg::OP_REMOVE, 16'd12);
        send(rsu_pkg::OP_REMOVE, 16'd10);
        send(rsu_pkg::OP_REMOVE, 16'd11);
        send(rsu_pkg::OP_TEST, 16'hFFFF);
        send(rsu_pkg::OP_ADD, 16'hFFFF);
        send(rsu_pkg::OP_TEST, 16'hFFFF);

        for (int n = 0; n < 925; n++)
        begin
            if (n % 100 == 0)
            begin
                send_burst = ($urandom_range(0, 2) == 0);
                recv_burst = ($urandom_range(0, 2) == 0);
            end
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600)
                wait_idle();
            send(pick_op(), pick_pos());
        end
        send_burst = 1'b0;
        recv_burst = 1'b0;

        wait_idle();
        repeat (100) @(posedge clk);
        $display("Checked %0d results: directed edge cases and %0d random requests,",
                 sb.checked, 925);
        $display("with random gaps, bursts, a long result stall and one full drain.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
